[hw/rtl/tdvs_pkg.sv]
// ----------------------------------------------------------------------------
// tdvs_pkg: shared types and constants
// Register map, opcodes, rule codes and the sequencer states of the
// thrash detector and victim selector.
// ----------------------------------------------------------------------------
package tdvs_pkg;

  localparam int unsigned MaxEntriesDefault   = 16;
  localparam int unsigned HistoryDepthDefault = 8;

  localparam logic [31:0] FreePageLimitReset = 32'd5000;
  localparam logic [31:0] FaultLimitReset    = 32'd3;
  localparam logic [31:0] WriteoutFloorReset = 32'd3;

  // Register indexes.
  localparam logic [1:0] RegFreePageLimit = 2'd0;
  localparam logic [1:0] RegFaultLimit    = 2'd1;
  localparam logic [1:0] RegWriteoutFloor = 2'd2;
  localparam logic [1:0] RegActiveEntries = 2'd3;

  // Opcodes.
  localparam logic OpWrite = 1'b0;
  localparam logic OpTick  = 1'b1;

  // Rule codes.
  localparam logic [2:0] RuleOverPeak    = 3'd0;
  localparam logic [2:0] RuleOverTypical = 3'd1;
  localparam logic [2:0] RuleFaults      = 3'd2;
  localparam logic [2:0] RuleLeastWorth  = 3'd3;
  localparam logic [2:0] RuleBiggest     = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_OUT
  } state_t;

endpackage

[hw/rtl/tdvs_scan.sv]
// ----------------------------------------------------------------------------
// tdvs_scan: slot store and scan unit
// Holds the service slots in a memory and walks the active slots one per
// cycle, keeping running best values for all five selection rules.
// ----------------------------------------------------------------------------
module tdvs_scan #(
  parameter int unsigned MAX_ENTRIES = tdvs_pkg::MaxEntriesDefault,
  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_addr,
  input  logic [31:0]   wr_rss,
  input  logic [31:0]   wr_peak,
  input  logic [31:0]   wr_typ,
  input  logic [15:0]   wr_worth,
  input  logic [31:0]   wr_fault,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_addr,
  input  logic          acc_en,
  input  logic          acc_first,
  input  logic [IW-1:0] acc_idx,
  output logic          peak_any,
  output logic [IW-1:0] peak_pick,
  output logic          typ_any,
  output logic [IW-1:0] typ_pick,
  output logic          fault_spread,
  output logic [IW-1:0] fault_pick,
  output logic          worth_spread,
  output logic [IW-1:0] worth_pick,
  output logic [IW-1:0] rss_pick
);

  logic [31:0] rss_mem   [MAX_ENTRIES];
  logic [31:0] peak_mem  [MAX_ENTRIES];
  logic [31:0] typ_mem   [MAX_ENTRIES];
  logic [15:0] worth_mem [MAX_ENTRIES];
  logic [31:0] fault_mem [MAX_ENTRIES];

  logic [31:0] rss_q, peak_q, typ_q, fault_q;
  logic [15:0] worth_q;

  logic [31:0] peak_best, typ_best, fhi, flo, rss_best;
  logic [15:0] whi, wlo;

  logic        peak_over, typ_over;
  logic [31:0] peak_ex, typ_ex;

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rss_mem[wr_addr]   <= wr_rss;
      peak_mem[wr_addr]  <= wr_peak;
      typ_mem[wr_addr]   <= wr_typ;
      worth_mem[wr_addr] <= wr_worth;
      fault_mem[wr_addr] <= wr_fault;
    end
    if (rd_en) begin
      rss_q   <= rss_mem[rd_addr];
      peak_q  <= peak_mem[rd_addr];
      typ_q   <= typ_mem[rd_addr];
      worth_q <= worth_mem[rd_addr];
      fault_q <= fault_mem[rd_addr];
    end
  end

  // Excess over the two limits for the slot being scanned.
  assign peak_over = rss_q > peak_q;
  assign typ_over  = rss_q > typ_q;
  assign peak_ex   = rss_q - peak_q;
  assign typ_ex    = rss_q - typ_q;

  // Running best values; strict compares keep the lowest slot on ties.
  always_ff @(posedge clk) begin
    if (acc_en) begin
      if (acc_first) begin
        peak_any   <= peak_over;
        peak_best  <= peak_ex;
        peak_pick  <= acc_idx;
        typ_any    <= typ_over;
        typ_best   <= typ_ex;
        typ_pick   <= acc_idx;
        fhi        <= fault_q;
        flo        <= fault_q;
        fault_pick <= acc_idx;
        whi        <= worth_q;
        wlo        <= worth_q;
        worth_pick <= acc_idx;
        rss_best   <= rss_q;
        rss_pick   <= acc_idx;
      end else begin
        if (peak_over && (!peak_any || peak_ex > peak_best)) begin
          peak_any  <= 1'b1;
          peak_best <= peak_ex;
          peak_pick <= acc_idx;
        end
        if (typ_over && (!typ_any || typ_ex > typ_best)) begin
          typ_any  <= 1'b1;
          typ_best <= typ_ex;
          typ_pick <= acc_idx;
        end
        if (fault_q > fhi) begin
          fhi        <= fault_q;
          fault_pick <= acc_idx;
        end
        if (fault_q < flo) begin
          flo <= fault_q;
        end
        if (worth_q > whi) begin
          whi <= worth_q;
        end
        if (worth_q < wlo) begin
          wlo        <= worth_q;
          worth_pick <= acc_idx;
        end
        if (rss_q > rss_best) begin
          rss_best <= rss_q;
          rss_pick <= acc_idx;
        end
      end
    end
  end

  assign fault_spread = flo < fhi;
  assign worth_spread = wlo < whi;

endmodule

[hw/rtl/thrash_detect_victim_select.sv]
// ----------------------------------------------------------------------------
// thrash_detect_victim_select: memory thrash detector and victim selector
// Tracks sustained memory pressure over sample ticks and picks one service
// slot to shed by a fixed order of rules.
// ----------------------------------------------------------------------------
// Usage: input items arrive on in_valid/in_ready. A write item (opcode 0)
// stores one service slot and gives no result. A tick item (opcode 1)
// gives one result on out_valid/out_ready with the pressure bits and, when
// the pressure history is full, the chosen victim and the rule used.
// Configuration must be written over the APB-style port only while idle;
// the block itself does not enforce this. A write item leaves the block
// idle and ready for the next item. A tick whose history is not full, or
// that finds no active slot, has its result the cycle after it is taken.
// A tick that searches for a victim scans the N active slots (at most
// MAX_ENTRIES) one slot per cycle and then the decide and output states.
// After a tick, the next item is accepted once the result has been taken.
// Reset (rst, synchronous) restores the register defaults and clears the
// pressure history; slot contents are undefined until written.
// When the receiver stalls, the result is held and no item is accepted.
// ----------------------------------------------------------------------------
module thrash_detect_victim_select #(
  parameter int unsigned MAX_ENTRIES   = tdvs_pkg::MaxEntriesDefault,
  parameter int unsigned HISTORY_DEPTH = tdvs_pkg::HistoryDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [3:0]  slot,
  input  logic [31:0] rss_pages,
  input  logic [31:0] peak_limit,
  input  logic [31:0] typical_size,
  input  logic [15:0] importance,
  input  logic [31:0] fault_count,
  input  logic [31:0] free_pages,
  input  logic [31:0] major_faults,
  input  logic [31:0] pages_written,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        momentary_pressure,
  output logic        sustained_pressure,
  output logic        victim_found,
  output logic [3:0]  victim_slot,
  output logic [2:0]  rule_used
);

  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned NW = $clog2(MAX_ENTRIES + 1);

  logic [31:0] free_page_limit, fault_limit, writeout_floor;
  logic [4:0]  active_entries;
  logic [HISTORY_DEPTH-1:0] history_bits, history_bits_next;

  tdvs_pkg::state_t state, state_next;
  logic [NW-1:0] n_act;
  logic [NW-1:0] rd_cnt, rd_cnt_next;
  logic [NW-1:0] acc_cnt, acc_cnt_next;
  logic          acc_en;

  logic        wr_en, accept, mom, cfg_wr;
  logic        peak_any, typ_any, fault_spread, worth_spread;
  logic [IW-1:0] peak_pick, typ_pick, fault_pick, worth_pick, rss_pick, pick;
  logic [2:0]  rule;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      free_page_limit <= tdvs_pkg::FreePageLimitReset;
      fault_limit     <= tdvs_pkg::FaultLimitReset;
      writeout_floor  <= tdvs_pkg::WriteoutFloorReset;
      active_entries  <= 5'd0;
    end else if (cfg_wr && paddr[1:0] == 2'b00) begin
      unique case (paddr[3:2])
        tdvs_pkg::RegFreePageLimit: free_page_limit <= pwdata;
        tdvs_pkg::RegFaultLimit:    fault_limit     <= pwdata;
        tdvs_pkg::RegWriteoutFloor: writeout_floor  <= pwdata;
        tdvs_pkg::RegActiveEntries: active_entries  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      tdvs_pkg::RegFreePageLimit: prdata = free_page_limit;
      tdvs_pkg::RegFaultLimit:    prdata = fault_limit;
      tdvs_pkg::RegWriteoutFloor: prdata = writeout_floor;
      tdvs_pkg::RegActiveEntries: prdata = {27'd0, active_entries};
      default:                    prdata = 32'd0;
    endcase
  end

  // Active slot count, clamped to the store depth.
  always_comb begin
    if ({27'd0, active_entries} > MAX_ENTRIES) n_act = NW'(MAX_ENTRIES);
    else n_act = NW'(active_entries);
  end

  // Momentary pressure rule.
  always_comb begin
    if (free_pages > free_page_limit)     mom = 1'b0;
    else if (major_faults > fault_limit)  mom = 1'b1;
    else if (pages_written < writeout_floor) mom = 1'b0;
    else mom = 1'b1;
  end

  assign in_ready = (state == tdvs_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign wr_en    = accept && opcode == tdvs_pkg::OpWrite &&
                    {28'd0, slot} < MAX_ENTRIES;

  tdvs_scan #(.MAX_ENTRIES(MAX_ENTRIES)) u_scan (
    .clk          (clk),
    .wr_en        (wr_en),
    .wr_addr      (IW'(slot)),
    .wr_rss       (rss_pages),
    .wr_peak      (peak_limit),
    .wr_typ       (typical_size),
    .wr_worth     (importance),
    .wr_fault     (fault_count),
    .rd_en        (state == tdvs_pkg::ST_SCAN),
    .rd_addr      (rd_cnt[IW-1:0]),
    .acc_en       (acc_en),
    .acc_first    (acc_cnt == '0),
    .acc_idx      (acc_cnt[IW-1:0]),
    .peak_any     (peak_any),
    .peak_pick    (peak_pick),
    .typ_any      (typ_any),
    .typ_pick     (typ_pick),
    .fault_spread (fault_spread),
    .fault_pick   (fault_pick),
    .worth_spread (worth_spread),
    .worth_pick   (worth_pick),
    .rss_pick     (rss_pick)
  );

  // Rule priority over the scan results.
  always_comb begin
    priority if (peak_any) begin
      pick = peak_pick; rule = tdvs_pkg::RuleOverPeak;
    end else if (typ_any) begin
      pick = typ_pick; rule = tdvs_pkg::RuleOverTypical;
    end else if (fault_spread) begin
      pick = fault_pick; rule = tdvs_pkg::RuleFaults;
    end else if (worth_spread) begin
      pick = worth_pick; rule = tdvs_pkg::RuleLeastWorth;
    end else begin
      pick = rss_pick; rule = tdvs_pkg::RuleBiggest;
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= tdvs_pkg::ST_IDLE;
      history_bits <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      history_bits <= history_bits_next;
      out_valid    <= (state_next == tdvs_pkg::ST_OUT);
    end
    rd_cnt  <= rd_cnt_next;
    acc_cnt <= acc_cnt_next;
    acc_en  <= (state == tdvs_pkg::ST_SCAN);
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (accept && opcode == tdvs_pkg::OpTick) begin
      momentary_pressure <= mom;
      sustained_pressure <= &{history_bits[HISTORY_DEPTH-2:0], mom};
      victim_found       <= 1'b0;
      victim_slot        <= 4'd0;
      rule_used          <= 3'd0;
    end else if (state == tdvs_pkg::ST_DECIDE && sustained_pressure && n_act != '0) begin
      victim_found <= 1'b1;
      victim_slot  <= 4'(pick);
      rule_used    <= rule;
    end
  end

  // Next state, counters and history.
  always_comb begin
    state_next        = state;
    rd_cnt_next       = rd_cnt;
    acc_cnt_next      = acc_cnt;
    history_bits_next = history_bits;
    unique case (state)
      tdvs_pkg::ST_IDLE: begin
        rd_cnt_next  = '0;
        acc_cnt_next = '0;
        if (accept && opcode == tdvs_pkg::OpTick) begin
          history_bits_next = {history_bits[HISTORY_DEPTH-2:0], mom};
          if (&{history_bits[HISTORY_DEPTH-2:0], mom} && n_act != '0)
            state_next = tdvs_pkg::ST_SCAN;
          else
            state_next = tdvs_pkg::ST_OUT;
        end
      end
      tdvs_pkg::ST_SCAN: begin
        rd_cnt_next = rd_cnt + 1'b1;
        if (acc_en) acc_cnt_next = acc_cnt + 1'b1;
        if (rd_cnt + 1'b1 == n_act) state_next = tdvs_pkg::ST_DECIDE;
      end
      tdvs_pkg::ST_DECIDE: begin
        if (acc_en) begin
          acc_cnt_next = acc_cnt + 1'b1;
        end else begin
          history_bits_next = {history_bits[HISTORY_DEPTH-1:1], 1'b0};
          state_next        = tdvs_pkg::ST_OUT;
        end
      end
      tdvs_pkg::ST_OUT: begin
        if (out_ready) state_next = tdvs_pkg::ST_IDLE;
      end
      default: state_next = tdvs_pkg::ST_IDLE;
    endcase
  end

endmodule
